// ===== design/wmma_pkg.sv =====
package wmma_pkg;

	localparam int FRAME_W = 32;
	localparam int SAMPLE_W = 32;
	localparam int MAG_W = 31;
	localparam int COUNT_W = 7;

	typedef struct packed {
		logic        [FRAME_W-1:0]  frame_number;
		logic signed [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] newest;
		logic        [COUNT_W-1:0]  usable_count;
		logic        [MAG_W-1:0]    mean;
		logic        [MAG_W-1:0]    smallest;
		logic        [MAG_W-1:0]    largest;
	} out_item_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	typedef logic [3:0] upc_t;

	localparam upc_t ST_CLEAR    = 4'd0;
	localparam upc_t ST_WAIT     = 4'd1;
	localparam upc_t ST_MOD      = 4'd2;
	localparam upc_t ST_MOD_FIX  = 4'd3;
	localparam upc_t ST_WRITE    = 4'd4;
	localparam upc_t ST_SCAN     = 4'd5;
	localparam upc_t ST_MEAN     = 4'd6;
	localparam upc_t ST_MEAN_RUN = 4'd7;
	localparam upc_t ST_FINISH   = 4'd8;

	typedef enum logic [3:0] {
		ACT_CLEAR     = 4'd0,
		ACT_WAIT      = 4'd1,
		ACT_MOD_MUL   = 4'd2,
		ACT_DIV_STEP  = 4'd3,
		ACT_WRITE     = 4'd4,
		ACT_SCAN      = 4'd5,
		ACT_MEAN_LOAD = 4'd6,
		ACT_FINISH    = 4'd7,
		ACT_MOD_FIX   = 4'd8
	} act_t;

	typedef enum logic [2:0] {
		COND_ALWAYS    = 3'd0,
		COND_ACCEPT    = 3'd1,
		COND_POW2      = 3'd2,
		COND_DIV_DONE  = 3'd3,
		COND_SCAN_DONE = 3'd4,
		COND_EMPTY     = 3'd5,
		COND_OUT_FREE  = 3'd6,
		COND_CLR_DONE  = 3'd7
	} cond_t;

	typedef struct packed {
		act_t  act;
		cond_t cond;
		upc_t  on_true;
		upc_t  on_false;
	} uword_t;

	function automatic uword_t ucode(input upc_t step);
		uword_t w;
		unique case (step)
			ST_CLEAR:    w = '{ACT_CLEAR,     COND_CLR_DONE,  ST_WAIT,     ST_CLEAR};
			ST_WAIT:     w = '{ACT_WAIT,      COND_ACCEPT,    ST_MOD,      ST_WAIT};
			ST_MOD:      w = '{ACT_MOD_MUL,   COND_POW2,      ST_WRITE,    ST_MOD_FIX};
			ST_MOD_FIX:  w = '{ACT_MOD_FIX,   COND_ALWAYS,    ST_WRITE,    ST_WRITE};
			ST_WRITE:    w = '{ACT_WRITE,     COND_ALWAYS,    ST_SCAN,     ST_SCAN};
			ST_SCAN:     w = '{ACT_SCAN,      COND_SCAN_DONE, ST_MEAN,     ST_SCAN};
			ST_MEAN:     w = '{ACT_MEAN_LOAD, COND_EMPTY,     ST_FINISH,   ST_MEAN_RUN};
			ST_MEAN_RUN: w = '{ACT_DIV_STEP,  COND_DIV_DONE,  ST_FINISH,   ST_MEAN_RUN};
			ST_FINISH:   w = '{ACT_FINISH,    COND_OUT_FREE,  ST_WAIT,     ST_FINISH};
			default:     w = '{ACT_WAIT,      COND_ALWAYS,    ST_WAIT,     ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

// ===== design/wmma_div.sv =====
module wmma_div #(
	parameter int DW = 38,
	parameter int VW = 7
) (
	input  logic                clk,
	input  logic                arst_n,
	input  wmma_pkg::div_ctl_t  ctl,
	input  logic [DW-1:0]       dividend,
	input  logic [VW-1:0]       divisor,
	output logic [DW-1:0]       quotient,
	output logic                done
);

	localparam int NW = $clog2(DW + 1);
	localparam logic [NW-1:0] LAST = NW'(DW);

	logic [NW-1:0] cnt_q;
	logic [DW-1:0] quot_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] div_q;
	logic [VW:0]   shifted;
	logic [VW:0]   diff;

	assign shifted = {rem_q, quot_q[DW-1]};
	assign diff = shifted - {1'b0, div_q};
	assign done = (cnt_q == LAST);
	assign quotient = quot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= LAST;
		end else if (ctl.load) begin
			cnt_q <= '0;
		end else if (ctl.step && !done) begin
			cnt_q <= cnt_q + NW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quot_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (ctl.step && !done) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quot_q <= {quot_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[VW-1:0];
				quot_q <= {quot_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== design/windowed_min_max_average_core.sv =====
// Sliding-window minimum, maximum and mean of Q16.16 timing samples.
// Input channel (in_valid / in_ready / in_item): one item carries a frame
// number and a sample; the sample overwrites slot frame_number mod
// HISTORY_DEPTH of the history window.
// Output channel (out_valid / out_ready / out_item): one item per input item
// with the newest sample, the count of strictly positive entries and their
// mean, minimum and maximum (all zero when there are none).
// A small control program steps a serial divider for the mean, the window
// memory and the min/max/sum datapath, one item at a time.
// From input accept to out_valid an item passes the slot modulo, the window
// write, the memory scan and a bit-serial mean divide over D = divider width
// (max(32, 31 + clog2(HISTORY_DEPTH + 1)), 38 at depth 64) quotient bits;
// an empty window skips the divide, and a depth that is not a power of two
// also needs the remainder correction of the slot modulo (reciprocal multiply).
// The memory scan makes one read per cycle. One item is in work at a time,
// so a new item is taken only after the last one has gone into the output
// register. After reset the window is cleared to zero with in_ready low.
// A result waits in the output register while out_ready is low; the next
// item is still accepted and worked up to the point of delivery.
module windowed_min_max_average_core #(
	parameter int HISTORY_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  wmma_pkg::in_item_t   in_item,
	output logic                 out_valid,
	input  logic                 out_ready,
	output wmma_pkg::out_item_t  out_item
);

	localparam int AW = $clog2(HISTORY_DEPTH);
	localparam int CW = $clog2(HISTORY_DEPTH + 1);
	localparam int SW = wmma_pkg::MAG_W + CW;
	localparam int DW = (SW > wmma_pkg::FRAME_W) ? SW : wmma_pkg::FRAME_W;
	localparam int QW = 33 - AW;
	localparam int RW = AW + 1;
	localparam bit IS_POW2 = ((HISTORY_DEPTH & (HISTORY_DEPTH - 1)) == 0);
	localparam logic [CW-1:0] DEPTH_C = CW'(HISTORY_DEPTH);
	localparam logic [CW-1:0] LAST_C = CW'(HISTORY_DEPTH - 1);
	localparam logic [RW-1:0] DEPTH_R = RW'(HISTORY_DEPTH);
	localparam logic [32:0] RECIP_C = 33'((64'd1 << (32 + AW)) / 64'(HISTORY_DEPTH));

	wmma_pkg::upc_t      upc_q;
	wmma_pkg::uword_t    uw;
	logic                hit;
	wmma_pkg::in_item_t  in_q;
	logic [31:0]         mem [HISTORY_DEPTH];
	logic [31:0]         rd_data_q;
	logic [CW-1:0]       idx_q;
	logic                pend_q;
	logic [CW-1:0]       cnt_q;
	logic [SW-1:0]       sum_q;
	logic [wmma_pkg::MAG_W-1:0] lo_q;
	logic [wmma_pkg::MAG_W-1:0] hi_q;
	logic                out_valid_q;
	wmma_pkg::out_item_t out_q;
	wmma_pkg::div_ctl_t  div_ctl;
	logic [DW-1:0]       div_dividend;
	logic [CW-1:0]       div_divisor;
	logic [DW-1:0]       div_quot;
	logic                div_done;
	logic [64:0]         mod_prod;
	logic [QW-1:0]       quot_est_q;
	logic [31:0]         mod_back;
	logic [RW-1:0]       rem_est_q;
	logic [RW-1:0]       rem_sub;
	logic [AW-1:0]       slot;
	logic                we;
	logic [AW-1:0]       wa;
	logic [31:0]         wd;
	logic                positive;
	logic                accept;
	logic                out_free;
	logic                empty;
	logic                scan_issue;

	assign uw = wmma_pkg::ucode(upc_q);
	assign in_ready = (uw.act == wmma_pkg::ACT_WAIT);
	assign accept = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign out_free = !out_valid_q || out_ready;
	assign empty = (cnt_q == '0);
	assign scan_issue = (uw.act == wmma_pkg::ACT_SCAN) && (idx_q != DEPTH_C);

	always_comb begin
		unique case (uw.cond)
			wmma_pkg::COND_ALWAYS:    hit = 1'b1;
			wmma_pkg::COND_ACCEPT:    hit = accept;
			wmma_pkg::COND_POW2:      hit = IS_POW2;
			wmma_pkg::COND_DIV_DONE:  hit = div_done;
			wmma_pkg::COND_SCAN_DONE: hit = (idx_q == DEPTH_C) && !pend_q;
			wmma_pkg::COND_EMPTY:     hit = empty;
			wmma_pkg::COND_OUT_FREE:  hit = out_free;
			wmma_pkg::COND_CLR_DONE:  hit = (idx_q == LAST_C);
			default:                  hit = 1'b1;
		endcase
	end

	assign div_ctl.load = (uw.act == wmma_pkg::ACT_MEAN_LOAD);
	assign div_ctl.step = (uw.act == wmma_pkg::ACT_DIV_STEP);
	assign div_dividend = DW'(sum_q);
	assign div_divisor = cnt_q;

	wmma_div #(
		.DW(DW),
		.VW(CW)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.quotient  (div_quot),
		.done      (div_done)
	);

	assign mod_prod = 65'(in_q.frame_number) * 65'(RECIP_C);
	assign mod_back = in_q.frame_number - 32'(quot_est_q) * 32'(HISTORY_DEPTH);
	assign rem_sub = rem_est_q - DEPTH_R;
	assign slot = IS_POW2 ? in_q.frame_number[AW-1:0] :
		((rem_est_q >= DEPTH_R) ? rem_sub[AW-1:0] : rem_est_q[AW-1:0]);
	assign we = (uw.act == wmma_pkg::ACT_CLEAR) || (uw.act == wmma_pkg::ACT_WRITE);
	assign wa = (uw.act == wmma_pkg::ACT_CLEAR) ? idx_q[AW-1:0] : slot;
	assign wd = (uw.act == wmma_pkg::ACT_CLEAR) ? '0 : in_q.sample;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd_data_q <= mem[idx_q[AW-1:0]];
	end

	assign positive = !rd_data_q[31] && (rd_data_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= wmma_pkg::ST_CLEAR;
			idx_q <= '0;
			pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			upc_q <= hit ? uw.on_true : uw.on_false;
			if (uw.act == wmma_pkg::ACT_CLEAR) begin
				idx_q <= idx_q + CW'(1);
			end else if (uw.act == wmma_pkg::ACT_WRITE) begin
				idx_q <= '0;
			end else if (scan_issue) begin
				idx_q <= idx_q + CW'(1);
			end
			pend_q <= scan_issue;
			if ((uw.act == wmma_pkg::ACT_FINISH) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			in_q <= in_item;
		end
		if (uw.act == wmma_pkg::ACT_MOD_MUL) begin
			quot_est_q <= mod_prod[64:32+AW];
		end
		if (uw.act == wmma_pkg::ACT_MOD_FIX) begin
			rem_est_q <= mod_back[RW-1:0];
		end
		if (uw.act == wmma_pkg::ACT_WRITE) begin
			cnt_q <= '0;
			sum_q <= '0;
			lo_q <= '1;
			hi_q <= '0;
		end else if (pend_q && positive) begin
			cnt_q <= cnt_q + CW'(1);
			sum_q <= sum_q + SW'(rd_data_q[wmma_pkg::MAG_W-1:0]);
			if (rd_data_q[wmma_pkg::MAG_W-1:0] < lo_q) begin
				lo_q <= rd_data_q[wmma_pkg::MAG_W-1:0];
			end
			if (rd_data_q[wmma_pkg::MAG_W-1:0] > hi_q) begin
				hi_q <= rd_data_q[wmma_pkg::MAG_W-1:0];
			end
		end
		if ((uw.act == wmma_pkg::ACT_FINISH) && out_free) begin
			out_q.newest <= in_q.sample;
			out_q.usable_count <= wmma_pkg::COUNT_W'(cnt_q);
			out_q.mean <= empty ? '0 : div_quot[wmma_pkg::MAG_W-1:0];
			out_q.smallest <= empty ? '0 : lo_q;
			out_q.largest <= empty ? '0 : hi_q;
		end
	end

endmodule

// ===== design/wmma_chk.sv =====
module wmma_chk #(
	parameter int HISTORY_DEPTH = 64
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input wmma_pkg::in_item_t  in_item,
	input logic                out_valid,
	input logic                out_ready,
	input wmma_pkg::out_item_t out_item
);

	localparam bit NARROW = (HISTORY_DEPTH < 128);

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_item))
		else $error("input item dropped or changed while waiting");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item dropped or changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && NARROW && (out_item.usable_count == '0) |->
		(out_item.mean == '0) && (out_item.smallest == '0) && (out_item.largest == '0))
		else $error("empty window with nonzero statistics");

	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_item.usable_count != '0) |->
		(out_item.smallest <= out_item.mean) && (out_item.mean <= out_item.largest))
		else $error("mean outside minimum and maximum");

	a_newest_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.newest[31] && (out_item.newest != '0) |->
		(out_item.smallest <= out_item.newest[30:0]) &&
		(out_item.largest >= out_item.newest[30:0]) &&
		(!NARROW || (out_item.usable_count != '0)))
		else $error("newest positive sample not reflected in statistics");

endmodule

bind windowed_min_max_average_core wmma_chk #(
	.HISTORY_DEPTH(HISTORY_DEPTH)
) u_wmma_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	localparam int DEPTH = 64;
	localparam int SLOT_W = $clog2(DEPTH);
	localparam int PHASE_ITEMS = 440;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 150;

	localparam int CLS_ANY = 0;
	localparam int CLS_TYPICAL = 1;
	localparam int CLS_EDGY = 2;
	localparam int CLS_NEAR_MAX = 3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	wmma_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	wmma_pkg::out_item_t out_item;

	wmma_pkg::in_item_t pending_items[$];
	wmma_pkg::out_item_t expected_stats[$];
	wmma_pkg::out_item_t oldest_stats;
	logic [31:0] window_copy [DEPTH];
	int sender_idle_pct = 23;
	int receiver_idle_pct = 57;
	int error_count = 0;
	int quiet_cycles = 0;

	windowed_min_max_average_core #(.HISTORY_DEPTH(DEPTH)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_item(in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item(out_item)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic wmma_pkg::out_item_t window_stats(wmma_pkg::in_item_t it);
		wmma_pkg::out_item_t r;
		logic [63:0] total;
		logic [63:0] hits;
		logic [30:0] lo;
		logic [30:0] hi;
		logic [SLOT_W-1:0] wslot;
		wslot = SLOT_W'(it.frame_number % 32'(DEPTH));
		window_copy[wslot] = it.sample;
		total = '0;
		hits = '0;
		lo = '1;
		hi = '0;
		foreach (window_copy[i]) begin
			if (window_copy[i] != 32'd0 && !window_copy[i][31]) begin
				hits = hits + 64'd1;
				total = total + 64'(window_copy[i]);
				if (window_copy[i][30:0] < lo)
					lo = window_copy[i][30:0];
				if (window_copy[i][30:0] > hi)
					hi = window_copy[i][30:0];
			end
		end
		r.newest = it.sample;
		r.usable_count = hits[6:0];
		if (hits != 0) begin
			r.mean = 31'(total / hits);
			r.smallest = lo;
			r.largest = hi;
		end else begin
			r.mean = '0;
			r.smallest = '0;
			r.largest = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("%0t mismatch on %s: got %h, expected %h", $time, what, got, want);
		error_count++;
	endtask

	task automatic push_item(logic [31:0] frame, logic [31:0] smp);
		wmma_pkg::in_item_t it;
		it.frame_number = frame;
		it.sample = smp;
		pending_items.push_back(it);
	endtask

	function automatic logic [31:0] make_sample(int cls);
		logic [31:0] v;
		case (cls)
			CLS_TYPICAL: begin
				v = $urandom_range(32'h0064_0000, 1);
			end
			CLS_EDGY: begin
				case ($urandom_range(3))
					0: v = $urandom_range(16, 1);
					1: v = 32'd0;
					2: v = 32'hFFFF_FFFF;
					default: v = {1'b1, 31'($urandom)};
				endcase
			end
			CLS_NEAR_MAX: begin
				v = 32'h7FFF_FFFF - $urandom_range(1000);
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	task automatic wait_drained();
		while (pending_items.size() != 0 || in_valid || expected_stats.size() != 0)
			@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_items.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= receiver_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					report_mismatch("result with no item outstanding",
						64'(out_item.newest), '0);
				end else begin
					oldest_stats = expected_stats.pop_front();
					if (out_item.newest !== oldest_stats.newest)
						report_mismatch("newest", 64'(out_item.newest),
							64'(oldest_stats.newest));
					if (out_item.usable_count !== oldest_stats.usable_count)
						report_mismatch("usable_count", 64'(out_item.usable_count),
							64'(oldest_stats.usable_count));
					if (out_item.mean !== oldest_stats.mean)
						report_mismatch("mean", 64'(out_item.mean), 64'(oldest_stats.mean));
					if (out_item.smallest !== oldest_stats.smallest)
						report_mismatch("smallest", 64'(out_item.smallest),
							64'(oldest_stats.smallest));
					if (out_item.largest !== oldest_stats.largest)
						report_mismatch("largest", 64'(out_item.largest),
							64'(oldest_stats.largest));
				end
			end
			if (in_valid && in_ready)
				expected_stats.push_back(window_stats(in_item));
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT)
			@(negedge clk);
		$display("[windowed_min_max_average_core] ERROR");
		$finish;
	end

	initial begin
		int produced;
		int mode;
		int cls;
		int len;
		logic [31:0] base;
		foreach (window_copy[i])
			window_copy[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_item(32'd0, 32'd0);
		push_item(32'd1, 32'h7FFF_FFFF);
		push_item(32'd2, 32'd1);
		push_item(32'd3, 32'hFFFF_FFFF);
		push_item(32'd4, 32'h8000_0000);
		push_item(32'd5, 32'h0001_0000);
		push_item(32'd1, 32'hFFFF_FFFB);
		push_item(32'hFFFF_FFFF, 32'h0000_8000);
		push_item(32'h0000_0040, 32'd0);
		push_item(32'hFFFF_FFC2, 32'h7FFF_FFFE);
		push_item(32'h8000_0003, 32'd3);
		push_item(32'h0000_0000, 32'h7FFF_FFFF);
		push_item(32'hFFFF_FFFE, 32'h0000_0001);
		push_item(32'h0000_0002, 32'h0000_0000);
		push_item(32'h7FFF_FFC5, 32'hAAAA_AAAA);
		push_item(32'h5555_5545, 32'h5555_5555);
		push_item(32'hFFFF_FFC2, 32'hFFFF_FFFF);
		push_item(32'hFFFF_FFFF, 32'h8000_0000);
		push_item(32'h0000_0045, 32'h8000_0001);
		push_item(32'h0000_0081, 32'h0000_0002);
		wait_drained();

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct = 23;
					receiver_idle_pct = 57;
				end
				1: begin
					sender_idle_pct = 57;
					receiver_idle_pct = 23;
				end
				default: begin
					sender_idle_pct = 0;
					receiver_idle_pct = 0;
				end
			endcase
			produced = 0;
			while (produced < PHASE_ITEMS) begin
				mode = $urandom_range(99);
				base = $urandom;
				if (mode < 60) begin
					len = $urandom_range(80, 1);
					cls = $urandom_range(CLS_NEAR_MAX, CLS_ANY);
					for (int j = 0; j < len; j++)
						push_item(base + j, make_sample(cls));
					produced += len;
				end else if (mode < 70) begin
					for (int j = 0; j < DEPTH; j++)
						push_item(base + j, make_sample(CLS_NEAR_MAX));
					produced += DEPTH;
				end else if (mode < 78) begin
					for (int j = 0; j < DEPTH; j++)
						push_item(base + j, $urandom_range(1) ? 32'd0 : {1'b1, 31'($urandom)});
					produced += DEPTH;
				end else begin
					push_item(base, $urandom);
					produced++;
				end
			end
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0 && expected_stats.size() == 0)
			$display("[windowed_min_max_average_core] OK");
		else
			$display("[windowed_min_max_average_core] ERROR");
		$finish;
	end

endmodule
